>>> src/moving_average_window_assert.svh
// Assertion macros shared by the moving average window checker.
`ifndef MOVING_AVERAGE_WINDOW_ASSERT_SVH
`define MOVING_AVERAGE_WINDOW_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAVW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("moving average window: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MAVW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("moving average window: next-cycle check failed");

`endif

>>> src/mavw_pkg.sv
// Package with shared constants and types of the moving average window.
`timescale 1ns / 1ps
package mavw_pkg;

	localparam int SAMPLE_W = 32;
	localparam int WINDOW_W = 7;
	localparam int MAX_WINDOW_DEF = 64;
	localparam logic [WINDOW_W-1:0] WINDOW_RST = 7'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DONE
	} mavw_state_t;

	// Status of the serial divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mavw_div_stat_t;

endpackage

>>> src/moving_average_window.sv
// An accepted number is written to the history; the kept entries are then read back from the
// newest and summed, the one-bit-per-cycle serial divider divides the sum by the kept count,
// and the result moves into the output register. No new item is taken until that result is
// loaded, so a stalled output holds the block. A non-number goes straight to the output with
// ok low. Reset clears pointers, count, state and window (to 8); the history memory is not
// cleared, because only entries written since reset are read.
`timescale 1ns / 1ps
module moving_average_window
	import mavw_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input channel.
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       is_number,
	// Output channel.
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] average,
	output logic                       ok,
	// Configuration write channel.
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [WINDOW_W-1:0]        window_length
);

	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int CMP_W = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_WINDOW - 1);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_WINDOW);
	localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_WINDOW);

	mavw_state_t state_q, state_d;

	logic [WINDOW_W-1:0] window_q;
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    kept_q;
	logic [CNT_W-1:0]    left_q;
	logic                rd_pend_q;
	logic [SUM_W-1:0]    sum_q;
	logic                ok_item_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] average_q;
	logic                ok_q;

	logic                accept;
	logic                wr_en;
	logic                rd_en;
	logic                out_load;
	logic                div_start;
	logic [CMP_W-1:0]    win_ext;
	logic [CMP_W-1:0]    win_eff;
	logic [CNT_W-1:0]    kept_inc;
	logic [CMP_W-1:0]    kept_cmp;
	logic [CNT_W-1:0]    kept_new;
	logic [SAMPLE_W-1:0] rd_data;
	logic [SUM_W-1:0]    sample_ext;
	logic [SUM_W-1:0]    sum_mag;
	logic [SUM_W-1:0]    div_quot;
	logic [SAMPLE_W-1:0] quot_low;
	logic [SAMPLE_W-1:0] mean;
	mavw_div_stat_t      div_stat;

	// An item transfers only while the sequencer is idle; a finished result may still
	// be waiting in the output register at that time.
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign wr_en     = accept && is_number;

	// Effective window: zero acts as one and anything above the history depth is clamped.
	assign win_ext = CMP_W'(window_q);
	always_comb begin
		if (win_ext == '0) begin
			win_eff = CMP_W'(1);
		end else if (win_ext > MAX_CMP) begin
			win_eff = MAX_CMP;
		end else begin
			win_eff = win_ext;
		end
	end

	// The kept count grows by one per accepted number and is cut back to the window,
	// which also drops the oldest entries after the window has shrunk.
	assign kept_inc = (kept_q < MAX_CNT) ? kept_q + CNT_W'(1) : kept_q;
	assign kept_cmp = CMP_W'(kept_inc);
	assign kept_new = (kept_cmp > win_eff) ? win_eff[CNT_W-1:0] : kept_inc;

	// One history read per cycle while entries remain, walking back from the newest.
	assign rd_en = (state_q == ST_SUM) && (left_q != '0);

	mavw_ring #(
		.DEPTH  (MAX_WINDOW),
		.ADDR_W (PTR_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_ptr_q),
		.wr_data (sample),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	assign sample_ext = {{CNT_W{rd_data[SAMPLE_W-1]}}, rd_data};

	// The divider works on magnitudes, so the quotient truncates toward zero once the
	// sign of the sum is put back.
	assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

	mavw_divider #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.divisor  (kept_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	assign quot_low = div_quot[SAMPLE_W-1:0];
	assign mean     = sum_q[SUM_W-1] ? (~quot_low + SAMPLE_W'(1)) : quot_low;

	// The result moves into the output register once that register is empty or is
	// being emptied by a transfer in the same cycle.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = is_number ? ST_SUM : ST_DONE;
				end
			end
			ST_SUM: begin
				if ((left_q == '0) && !rd_pend_q) begin
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done && !div_stat.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= window_length;
		end
	end

	// History pointers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			kept_q    <= '0;
			left_q    <= '0;
			rd_pend_q <= 1'b0;
			ok_item_q <= 1'b0;
		end else begin
			rd_pend_q <= rd_en;
			if (accept) begin
				ok_item_q <= is_number;
			end
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
				rd_ptr_q <= wr_ptr_q;
				kept_q   <= kept_new;
				left_q   <= kept_new;
			end else if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == '0) ? LAST_PTR : rd_ptr_q - PTR_W'(1);
				left_q   <= left_q - CNT_W'(1);
			end
		end
	end

	// Accumulator: the wide sum cannot overflow for any window up to the history depth.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			sum_q <= '0;
		end else if (rd_pend_q) begin
			sum_q <= sum_q + sample_ext;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			average_q <= ok_item_q ? mean : '0;
			ok_q      <= ok_item_q;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign ok        = ok_q;

endmodule

>>> src/mavw_ring.sv
// Sample history memory with one write port and one registered read port.
`timescale 1ns / 1ps
module mavw_ring
	import mavw_pkg::*;
#(
	parameter int DEPTH = MAX_WINDOW_DEF,
	parameter int ADDR_W = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  logic [SAMPLE_W-1:0] wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output logic [SAMPLE_W-1:0] rd_data
);

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/mavw_divider.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
module mavw_divider
	import mavw_pkg::*;
#(
	parameter int NUM_W = 39,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output mavw_div_stat_t   stat,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] divisor_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// The remainder stays below the divisor, so the trial value fits one extra bit.
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			divisor_q <= divisor;
			quot_q    <= dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quot_q;

endmodule

>>> src/mavw_checker.sv
// Port-level checker for the moving average window, bound to the top level.
`timescale 1ns / 1ps
`include "moving_average_window_assert.svh"
module mavw_checker
	import mavw_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] average,
	input logic                       ok
);

	// A held result keeps its contents.
	`MAVW_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(average) && $stable(ok))

	// A rejected reading always reports a zero average.
	`MAVW_ASSERT_IMP(a_reject_zero, clk, arst_n, out_valid && !ok, average == '0)

	// The block is busy in the cycle after it takes an item.
	`MAVW_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall)

	// A new result only appears while an item was being worked on.
	`MAVW_ASSERT_IMP(a_result_from_item, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind moving_average_window mavw_checker u_mavw_checker (.*);
